FILE: design/rlfe_pkg.sv
// Shared types and constants for the linear RGB fade engine.
// Used by the controller, the datapath and the top level.
package rlfe_pkg;

  // Item mode codes
  localparam logic [2:0] ModeTick  = 3'd0;
  localparam logic [2:0] ModeAll   = 3'd1;
  localparam logic [2:0] ModeRed   = 3'd2;
  localparam logic [2:0] ModeGreen = 3'd3;
  localparam logic [2:0] ModeBlue  = 3'd4;

  localparam int unsigned NumChan  = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DivW     = TimeW + 8;
  localparam int unsigned DivSteps = 9;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [7:0]  FullProg = 8'hFF;

  typedef struct packed {
    logic [2:0]       mode;
    logic [TimeW-1:0] now_ms;
    logic [7:0]       target_red;
    logic [7:0]       target_green;
    logic [7:0]       target_blue;
    logic [TimeW-1:0] fade_length;
    logic [7:0]       external_progress;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       busy_res;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic apply_req;
    logic load_ext;
    logic div_init;
    logic div_step;
    logic prog_div;
    logic scale;
    logic apply;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_req;
    logic fading;
    logic len_zero;
  } status_t;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StEval   = 8'b0000_0010,
    StMul    = 8'b0000_0100,
    StDiv    = 8'b0000_1000,
    StProg   = 8'b0001_0000,
    StScale  = 8'b0010_0000,
    StApply  = 8'b0100_0000,
    StResult = 8'b1000_0000
  } state_e;

endpackage

FILE: design/rlfe_ctrl.sv
// Sequencing state machine for the fade engine.
// Depends on rlfe_pkg; drives rlfe_dp through cmd_t and reads status_t.
module rlfe_ctrl
  import rlfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        if (status_i.is_req) begin
          cmd_o.apply_req = !status_i.fading;
          state_d         = StResult;
        end else if (!status_i.fading) begin
          state_d = StResult;
        end else if (status_i.len_zero) begin
          cmd_o.load_ext = 1'b1;
          state_d        = StScale;
        end else begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CntW'(DivSteps - 1);
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StProg;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StProg: begin
        cmd_o.prog_div = 1'b1;
        state_d        = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StApply;
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d     = StResult;
      end
      StResult: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/rlfe_dp.sv
// Datapath of the fade engine: colour state, serial progress divider,
// per-channel scaling and the output register. Depends on rlfe_pkg.
module rlfe_dp
  import rlfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output out_t    out_data_o
);

  // Architectural state
  logic [NumChan-1:0][7:0] start_q, start_d;
  logic [NumChan-1:0][7:0] cur_q, cur_d;
  logic [NumChan-1:0][7:0] tgt_q, tgt_d;
  logic [NumChan-1:0][8:0] diff_q, diff_d;
  logic [TimeW-1:0]        start_ms_q, start_ms_d;
  logic [TimeW-1:0]        len_q, len_d;
  logic                    fading_q, fading_d;

  // Working registers
  in_t                      item_q;
  logic                     acc_q;
  logic [DivW-1:0]          rem_q;
  logic [DivW-1:0]          dv_q;
  logic [DivSteps-1:0]      quo_q;
  logic [7:0]               prog_q;
  logic [NumChan-1:0][17:0] prod_q;
  out_t                     out_q;

  logic [NumChan-1:0]      sel;
  logic [NumChan-1:0][7:0] req_tgt;
  logic [TimeW-1:0]        elapsed;
  logic                    ge;

  // Decode the item
  always_comb begin
    case (item_q.mode)
      ModeAll:   sel = 3'b111;
      ModeRed:   sel = 3'b001;
      ModeGreen: sel = 3'b010;
      ModeBlue:  sel = 3'b100;
      default:   sel = 3'b000;
    endcase
  end

  assign req_tgt[0] = item_q.target_red;
  assign req_tgt[1] = item_q.target_green;
  assign req_tgt[2] = item_q.target_blue;

  assign status_o.is_req   = (item_q.mode inside {[ModeAll:ModeBlue]});
  assign status_o.fading   = fading_q;
  assign status_o.len_zero = (len_q == '0);

  // Latch the item and run the divider
  assign elapsed = item_q.now_ms - start_ms_q;
  assign ge      = (rem_q >= dv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      acc_q <= cmd_i.apply_req;
    end
    if (cmd_i.div_init) begin
      // elapsed * 255 as (elapsed << 8) - elapsed
      rem_q <= {elapsed, 8'h00} - {8'h00, elapsed};
      dv_q  <= {len_q, 8'h00};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dv_q;
      end
      dv_q  <= {1'b0, dv_q[DivW-1:1]};
      quo_q <= {quo_q[DivSteps-2:0], ge};
    end
    if (cmd_i.load_ext) begin
      prog_q <= item_q.external_progress;
    end else if (cmd_i.prog_div) begin
      // saturate at full progress
      prog_q <= quo_q[DivSteps-1] ? FullProg : quo_q[7:0];
    end
    if (cmd_i.scale) begin
      for (int c = 0; c < NumChan; c++) begin
        prod_q[c] <= 18'($signed(diff_q[c]) * $signed({1'b0, prog_q}));
      end
    end
    if (cmd_i.load_out) begin
      out_q.accepted    <= acc_q;
      out_q.busy_res    <= fading_q;
      out_q.red_level   <= cur_q[0];
      out_q.green_level <= cur_q[1];
      out_q.blue_level  <= cur_q[2];
    end
  end

  // Update the colour state
  always_comb begin
    logic       neg;
    logic [16:0] mag;
    logic [16:0] sum;
    logic [7:0]  quot;
    logic [9:0]  step;
    logic [9:0]  val;
    logic        any_diff;

    start_d    = start_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    diff_d     = diff_q;
    start_ms_d = start_ms_q;
    len_d      = len_q;
    fading_d   = fading_q;
    any_diff   = 1'b0;
    neg        = 1'b0;
    mag        = '0;
    sum        = '0;
    quot       = '0;
    step       = '0;
    val        = '0;

    if (cmd_i.apply_req) begin
      for (int c = 0; c < NumChan; c++) begin
        start_d[c] = cur_q[c];
        if (sel[c]) begin
          tgt_d[c]  = req_tgt[c];
          diff_d[c] = 9'({2'b00, req_tgt[c]} - {2'b00, cur_q[c]});
        end else begin
          diff_d[c] = '0;
        end
        any_diff = any_diff | (diff_d[c] != '0);
      end
      start_ms_d = item_q.now_ms;
      len_d      = item_q.fade_length;
      fading_d   = any_diff;
    end else if (cmd_i.apply) begin
      for (int c = 0; c < NumChan; c++) begin
        // divide by 255 toward zero: (a + (a >> 8) + 1) >> 8 for a <= 65025
        neg  = prod_q[c][17];
        mag  = neg ? 17'(-prod_q[c]) : prod_q[c][16:0];
        sum  = mag + {8'h00, mag[16:8]} + 17'd1;
        quot = sum[15:8];
        step = neg ? 10'(-{2'b00, quot}) : {2'b00, quot};
        val  = {2'b00, start_q[c]} + step;
        cur_d[c] = val[7:0];
      end
      if (prog_q == FullProg) begin
        fading_d   = 1'b0;
        cur_d      = tgt_q;
        start_ms_d = '0;
        len_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      cur_q      <= '0;
      tgt_q      <= '0;
      diff_q     <= '0;
      start_ms_q <= '0;
      len_q      <= '0;
      fading_q   <= 1'b0;
    end else begin
      start_q    <= start_d;
      cur_q      <= cur_d;
      tgt_q      <= tgt_d;
      diff_q     <= diff_d;
      start_ms_q <= start_ms_d;
      len_q      <= len_d;
      fading_q   <= fading_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/rgb_linear_fade_engine.sv
// Linear RGB fade engine, top level.
// Requests and idle ticks go from evaluation to the result; other ticks are
// scaled and applied first, a timed tick after the serial progress divider.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset clears the colour, the fade state and valids.
module rgb_linear_fade_engine
  import rlfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  rlfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlfe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

endmodule

FILE: test/rgb_fade_checker.sv
// Scoreboard for the linear RGB fade engine: watches the request and result
// channels, predicts each result item and compares it field by field.
// Depends on rlfe_pkg for the item types and mode codes.
module rgb_fade_checker
  import rlfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted fade state
  logic [7:0]  base_shade [NumChan];
  logic [7:0]  live_shade [NumChan];
  logic [7:0]  goal_shade [NumChan];
  int          slope      [NumChan];
  logic [31:0] fade_start;
  logic [31:0] fade_len;
  logic        fading;

  out_t colour_due_q [$];
  out_t due;

  function automatic void clear_fade();
    for (int c = 0; c < NumChan; c++) begin
      base_shade[c] = '0;
      live_shade[c] = '0;
      goal_shade[c] = '0;
      slope[c]      = 0;
    end
    fade_start = '0;
    fade_len   = '0;
    fading     = 1'b0;
  endfunction

  // Advance the predicted state by one item and return the colour it reports
  function automatic out_t next_colour(input in_t it);
    logic [7:0]  want [NumChan];
    logic [31:0] span;
    logic [63:0] scaled;
    int          prog;
    int          mix;
    int          level;
    logic        moving;
    out_t        res;
    want = '{it.target_red, it.target_green, it.target_blue};
    res.accepted = 1'b0;
    if (it.mode >= ModeAll && it.mode <= ModeBlue) begin
      // latch a new fade only while idle; a request during a fade is dropped
      if (!fading) begin
        moving = 1'b0;
        for (int c = 0; c < NumChan; c++) begin
          base_shade[c] = live_shade[c];
          if (it.mode == ModeAll || int'(it.mode) == int'(ModeRed) + c) begin
            goal_shade[c] = want[c];
            slope[c] = int'(want[c]) - int'(base_shade[c]);
          end else begin
            slope[c] = 0;
          end
          if (slope[c] != 0) moving = 1'b1;
        end
        fade_start   = it.now_ms;
        fade_len     = it.fade_length;
        fading       = moving;
        res.accepted = 1'b1;
      end
    end else if (fading) begin
      // progress from the clock, or from outside when the length is zero
      if (fade_len == '0) begin
        prog = int'(it.external_progress);
      end else begin
        span   = it.now_ms - fade_start;
        scaled = (64'(span) * 64'd255) / 64'(fade_len);
        prog   = (scaled > 64'd255) ? 255 : int'(scaled);
      end
      for (int c = 0; c < NumChan; c++) begin
        mix   = (slope[c] * prog) / 255;
        level = int'(base_shade[c]) + mix;
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        live_shade[c] = 8'(level);
      end
      // full progress ends the fade and snaps to the target
      if (prog == 255) begin
        fading     = 1'b0;
        live_shade = goal_shade;
        fade_len   = '0;
        fade_start = '0;
      end
    end
    res.busy_res    = fading;
    res.red_level   = live_shade[0];
    res.green_level = live_shade[1];
    res.blue_level  = live_shade[2];
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Predict on each accepted request item, compare on each accepted result item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_fade();
      colour_due_q.delete();
      fail_count_o = 0;
      waiting_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) colour_due_q.push_back(next_colour(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (colour_due_q.size() == 0) begin
          $error("result item with no prediction waiting");
          fail_count_o++;
        end else begin
          due = colour_due_q.pop_front();
          check_field("accepted", due.accepted, out_data_i.accepted);
          check_field("busy_res", due.busy_res, out_data_i.busy_res);
          check_field("red_level", due.red_level, out_data_i.red_level);
          check_field("green_level", due.green_level, out_data_i.green_level);
          check_field("blue_level", due.blue_level, out_data_i.blue_level);
        end
      end
      waiting_o = colour_due_q.size();
    end
  end

endmodule

FILE: test/tb_rgb_linear_fade_engine.sv
// Testbench top for the linear RGB fade engine: drives request items, toggles
// result back-pressure and gives the verdict. Needs rlfe_pkg, the engine RTL
// and rgb_fade_checker.
module tb_rgb_linear_fade_engine;
  import rlfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the block treats as a tick
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam int         QuietLimit  = 2000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  int fail_count;
  int waiting;
  int quiet_cycles = 0;
  int items_sent;
  int idle_pct;
  int stall_pct;
  int idle_mix  [4] = '{0, 80, 0, 14};
  int stall_mix [4] = '{0, 0, 80, 14};

  // Colour the block should hold when idle, as far as the stimulus knows
  logic [7:0] shade [NumChan];
  bit         shade_known;

  rgb_linear_fade_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  rgb_fade_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random back-pressure on results
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_rgb_linear_fade_engine: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t tick_item(logic [2:0] mode, logic [31:0] now, logic [7:0] ext);
    in_t it;
    it.mode              = mode;
    it.now_ms            = now;
    it.target_red        = 8'($urandom);
    it.target_green      = 8'($urandom);
    it.target_blue       = 8'($urandom);
    it.fade_length       = $urandom;
    it.external_progress = ext;
    return it;
  endfunction

  function automatic in_t fade_item(logic [2:0] mode, logic [31:0] now, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b, logic [31:0] len);
    in_t it;
    it = tick_item(mode, now, 8'($urandom));
    it.target_red   = r;
    it.target_green = g;
    it.target_blue  = b;
    it.fade_length  = len;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
  endtask

  // One fade: request, ticks part of the way, then a tick that must finish it
  task automatic run_fade();
    logic [2:0]  mode;
    logic [7:0]  goal [NumChan];
    logic [31:0] t0;
    logic [31:0] span;
    int          kind;
    int          frac;
    int          roll;
    bit          clash;
    mode = ($urandom_range(2) == 0 || !shade_known) ? ModeAll :
           3'($urandom_range(ModeRed, ModeBlue));
    for (int c = 0; c < NumChan; c++) goal[c] = 8'($urandom);
    // sometimes ask for the colour already held, so the fade never starts
    if (shade_known && $urandom_range(7) == 0) goal = shade;
    kind = $urandom_range(9);
    if (kind < 2) span = '0;
    else if (kind < 6) span = $urandom_range(1, 300);
    else if (kind < 8) span = $urandom;
    else if (kind == 8) span = 32'hFFFF_FFFF;
    else span = $urandom_range(1, 8);
    t0 = $urandom;
    send_item(fade_item(mode, t0, goal[0], goal[1], goal[2], span));
    frac  = 0;
    clash = 1'b0;
    repeat ($urandom_range(1, 6)) begin
      frac += $urandom_range(1, 60);
      if (frac > 255) frac = 255;
      roll = $urandom_range(19);
      if (roll == 0) begin
        // stray request, zero length so the closing tick can still end it
        clash = 1'b1;
        send_item(fade_item(3'($urandom_range(ModeAll, ModeBlue)), $urandom, 8'($urandom),
                            8'($urandom), 8'($urandom), '0));
      end else if (roll == 1) begin
        // time running backwards wraps the elapsed count
        send_item(tick_item(ModeTick, t0 - 32'($urandom_range(1, 1000)), 8'($urandom)));
      end else begin
        send_item(tick_item(roll < 4 ? 3'($urandom_range(ModeSpareLo, ModeSpareHi)) : ModeTick,
                            t0 + 32'((64'(span) * 64'(frac)) >> 8), 8'($urandom)));
      end
    end
    send_item(tick_item(ModeTick, t0 + span, FullProg));
    if ($urandom_range(3) == 0) send_item(tick_item(ModeTick, $urandom, 8'($urandom)));
    for (int c = 0; c < NumChan; c++) begin
      if (mode == ModeAll || int'(mode) == int'(ModeRed) + c) shade[c] = goal[c];
    end
    if (clash) shade_known = 1'b0;
  endtask

  // Unstructured items, then a full-progress tick to return to idle
  task automatic run_noise();
    in_t it;
    repeat ($urandom_range(3, 8)) begin
      it = tick_item(3'($urandom), $urandom, 8'($urandom));
      if (it.mode >= ModeAll && it.mode <= ModeBlue) it.fade_length = '0;
      send_item(it);
    end
    send_item(tick_item(ModeTick, $urandom, FullProg));
    shade_known = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    items_sent  = 0;
    shade       = '{default: 8'h00};
    shade_known = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tick while idle, then a request that changes nothing
    send_item(tick_item(ModeTick, 32'h0000_0000, 8'h00));
    send_item(fade_item(ModeAll, 32'h0000_0040, 8'h00, 8'h00, 8'h00, 32'd5));
    // timed fade across the counter wrap, with a refused request and spare modes
    send_item(fade_item(ModeAll, 32'hFFFF_FFF0, 8'hFF, 8'hFF, 8'hFF, 32'h20));
    send_item(fade_item(ModeRed, 32'hFFFF_FFF8, 8'h00, 8'h00, 8'h00, 32'd0));
    send_item(tick_item(ModeSpareHi, 32'h0000_0000, 8'h00));
    send_item(tick_item(ModeSpareLo, 32'h0000_000F, 8'hFF));
    send_item(tick_item(ModeTick, 32'h0000_0010, 8'h00));
    // single channel, falling, driven from outside
    send_item(fade_item(ModeGreen, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF, 32'd0));
    send_item(tick_item(ModeTick, 32'h0000_0000, 8'h00));
    send_item(tick_item(ModeTick, 32'h0000_0001, 8'h01));
    send_item(tick_item(ModeSpareLo + 3'd1, 32'h0000_0002, 8'h80));
    send_item(tick_item(ModeTick, 32'h0000_0003, 8'hFF));
    // longest possible length
    send_item(fade_item(ModeBlue, 32'h0000_0000, 8'h00, 8'h00, 8'h80, 32'hFFFF_FFFF));
    send_item(tick_item(ModeTick, 32'h8000_0000, 8'h00));
    send_item(tick_item(ModeTick, 32'hFFFF_FFFF, 8'h00));
    // elapsed time wrapping to a huge value saturates progress
    send_item(fade_item(ModeRed, 32'h0000_1234, 8'h01, 8'hAA, 8'hAA, 32'd1));
    send_item(tick_item(ModeTick, 32'h0000_1233, 8'h00));
    // mixed signs, negative steps truncate toward zero
    send_item(fade_item(ModeAll, 32'd100, 8'h00, 8'hFF, 8'h55, 32'd3));
    send_item(tick_item(ModeTick, 32'd101, 8'h00));
    send_item(tick_item(ModeTick, 32'd102, 8'h00));
    send_item(tick_item(ModeTick, 32'd103, 8'h00));
    send_item(tick_item(ModeTick, 32'd104, 8'hFF));
    shade = '{8'h00, 8'hFF, 8'h55};

    // random fades under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      hold_until_drained();
      idle_pct  = idle_mix[phase];
      stall_pct = stall_mix[phase];
      while (items_sent < 22 + 120 * (phase + 1)) begin
        if ($urandom_range(5) == 0) run_noise();
        else run_fade();
      end
    end

    hold_until_drained();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && waiting == 0) begin
      $display("tb_rgb_linear_fade_engine: clean");
    end else begin
      $display("tb_rgb_linear_fade_engine: errors");
    end
    $finish;
  end

endmodule
